// File: rtl/wch_pkg.sv
package wch_pkg;

	// word and bitmap geometry
	localparam int WORD_BITS  = 24;
	localparam int SAMPLE_W   = 24;
	localparam int LANE_BITS  = 6;
	localparam int ROW_LANES  = 1 << LANE_BITS;
	localparam int ROW_BITS   = WORD_BITS - LANE_BITS;
	localparam int EPOCH_BITS = 8;

	// register widths
	localparam int LEN_W   = 25;
	localparam int COUNT_W = 24;
	localparam int CFG_W   = 25;
	localparam int IDX_W   = 2;

	// reset values of the registers, and the collision count ceiling
	localparam logic [LEN_W-1:0]   BLOCK_LEN_RST = LEN_W'(349525);
	localparam logic [COUNT_W-1:0] PASS_MIN_RST  = COUNT_W'(3464);
	localparam logic [COUNT_W-1:0] PASS_MAX_RST  = COUNT_W'(3770);
	localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

	// register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_BLOCK_LEN = 2'd0,
		REG_PASS_MIN  = 2'd1,
		REG_PASS_MAX  = 2'd2
	} cfg_reg_t;

	// one bitmap row: epoch tag and 64 seen bits
	typedef struct packed {
		logic [EPOCH_BITS-1:0] tag;
		logic [ROW_LANES-1:0]  bits;
	} row_t;

endpackage

// File: rtl/wch_if.sv
// sample request channel
interface wch_sample_if
	import wch_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_word;

	modport source (output valid, output sample_word, input ready);
	modport sink (input valid, input sample_word, output ready);
endinterface

// result request channel
interface wch_result_if
	import wch_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] collision_total;
	logic               passed;

	modport source (output valid, output collision_total, output passed, input ready);
	modport sink (input valid, input collision_total, input passed, output ready);
endinterface

// File: rtl/word_collision_health_test.sv
// channel   dir  payload                         handshake
// sample    in   sample_word[23:0]               valid/ready
// result    out  collision_total[23:0], passed   valid/ready
// cfg       in   cfg_index, cfg_wdata            cfg_we, no wait
//
// one sample per cycle while sample ready is high; the bitmap row
// read-modify-write reads into stage 1, with forwarding between neighbours;
// a result passes stage 1 and then the result queue after the closing sample
// after reset, and after every 256th block when the epoch tag wraps, a
// clearing pass writes all 2^(WORD_BITS-6) rows, one per cycle when no sample
// is in stage 1, with sample ready low
// a three-entry result queue parts the sides; sample ready drops only when
// the queue could overflow or a clearing pass runs
module word_collision_health_test
	import wch_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	wch_sample_if.sink         sample,
	wch_result_if.source       result,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_wdata
);

	localparam int OUT_DEPTH = 3;

	// configuration registers
	logic [LEN_W-1:0]   block_len_q;
	logic [COUNT_W-1:0] pass_min_q;
	logic [COUNT_W-1:0] pass_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_len_q <= BLOCK_LEN_RST;
			pass_min_q  <= PASS_MIN_RST;
			pass_max_q  <= PASS_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLOCK_LEN: block_len_q <= cfg_wdata[LEN_W-1:0];
				REG_PASS_MIN:  pass_min_q  <= cfg_wdata[COUNT_W-1:0];
				REG_PASS_MAX:  pass_max_q  <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// bitmap memory
	row_t               map_mem [1 << ROW_BITS];
	row_t               rd_row_s1;
	logic               wr_en;
	logic [ROW_BITS-1:0] wr_addr;
	row_t               wr_row;

	// pipeline and control state
	logic                 valid_s1, close_s1, fwd_s1;
	logic [ROW_BITS-1:0]  addr_s1;
	logic [LANE_BITS-1:0] lane_s1;
	logic [EPOCH_BITS-1:0] epoch_s1;
	row_t                 fwd_row_s1;
	logic [LEN_W-1:0]     words_q;
	logic [COUNT_W-1:0]   coll_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic                 sweep_q;
	logic [ROW_BITS-1:0]  sweep_addr_q;

	// result queue
	logic [COUNT_W-1:0]   oq_total [OUT_DEPTH];
	logic                 oq_pass  [OUT_DEPTH];
	logic [1:0]           oq_wr_q, oq_rd_q, oq_cnt_q;

	// input decode
	logic [WORD_BITS-1:0] word_val;
	logic [ROW_BITS-1:0]  addr_in;
	logic                 accept, close_in, push, pop;
	logic [LEN_W-1:0]     words_next;

	assign word_val   = WORD_BITS'(sample.sample_word);
	assign addr_in    = word_val[WORD_BITS-1:LANE_BITS];
	assign accept     = sample.valid && sample.ready;
	assign words_next = words_q + LEN_W'(1);
	assign close_in   = words_next >= block_len_q;

	// room for every result that may land in the queue, and no clearing pass
	assign sample.ready = !sweep_q &&
		(({1'b0, oq_cnt_q} + {2'b0, valid_s1 && close_s1}) <= 3'(OUT_DEPTH - 1));

	// modify: merge the row, detect a repeat; a clearing pass takes the write port when no sample is in stage 1
	row_t               cur_row;
	logic [ROW_LANES-1:0] live_bits;
	logic                 hit;
	logic [COUNT_W-1:0]   total;
	logic                 total_pass;

	always_comb begin
		cur_row    = fwd_s1 ? fwd_row_s1 : rd_row_s1;
		live_bits  = (cur_row.tag == epoch_s1) ? cur_row.bits : '0;
		hit        = live_bits[lane_s1];
		total      = (hit && coll_q != COUNT_MAX) ? coll_q + COUNT_W'(1) : coll_q;
		total_pass = (pass_min_q <= total) && (total <= pass_max_q);
		wr_row.tag  = epoch_s1;
		wr_row.bits = live_bits | (ROW_LANES'(1) << lane_s1);
		wr_en      = valid_s1;
		wr_addr    = addr_s1;
		if (!valid_s1 && sweep_q) begin
			wr_en   = 1'b1;
			wr_addr = sweep_addr_q;
			wr_row  = '0;
		end
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_row_s1 <= map_mem[addr_in];
		end
		if (wr_en) begin
			map_mem[wr_addr] <= wr_row;
		end
	end

	// stage 1 payload, forwarding of the row written in the same cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1    <= addr_in;
			lane_s1    <= word_val[LANE_BITS-1:0];
			epoch_s1   <= epoch_q;
			close_s1   <= close_in;
			fwd_s1     <= valid_s1 && (addr_s1 == addr_in);
			fwd_row_s1 <= wr_row;
		end
	end

	// block counters, epoch and clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			words_q      <= '0;
			coll_q       <= '0;
			epoch_q      <= '0;
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				words_q <= close_in ? '0 : words_next;
				if (close_in) begin
					epoch_q <= epoch_q + EPOCH_BITS'(1);
					if (epoch_q == '1) begin
						sweep_q      <= 1'b1;
						sweep_addr_q <= '0;
					end
				end
			end
			if (valid_s1) begin
				coll_q <= close_s1 ? '0 : total;
			end
			if (sweep_q && !valid_s1) begin
				sweep_addr_q <= sweep_addr_q + ROW_BITS'(1);
				if (sweep_addr_q == '1) begin
					sweep_q <= 1'b0;
				end
			end
		end
	end

	// result queue
	assign push = valid_s1 && close_s1;
	assign pop  = result.valid && result.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			oq_total[oq_wr_q] <= total;
			oq_pass[oq_wr_q]  <= total_pass;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (push) begin
				oq_wr_q <= (oq_wr_q == 2'(OUT_DEPTH - 1)) ? '0 : oq_wr_q + 2'd1;
			end
			if (pop) begin
				oq_rd_q <= (oq_rd_q == 2'(OUT_DEPTH - 1)) ? '0 : oq_rd_q + 2'd1;
			end
			oq_cnt_q <= oq_cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign result.valid           = oq_cnt_q != '0;
	assign result.collision_total = oq_total[oq_rd_q];
	assign result.passed          = oq_pass[oq_rd_q];

	// checks
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> oq_cnt_q < 2'(OUT_DEPTH))
		else $error("result queue overflow");

	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && close_s1 |=> coll_q == '0)
		else $error("collision count not cleared after block");

	a_epoch_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && close_in) |=> $stable(epoch_q))
		else $error("epoch moved without a closing sample");

	a_sweep_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_q && !valid_s1 |-> !accept && wr_en && wr_row == '0)
		else $error("clearing pass overlaps a sample");

endmodule
